// ===== hw/rtl/wht_pkg.sv =====
// Package for the weak handle table: operation and status codes, FSM states.
// No dependencies.
package wht_pkg;

  typedef enum logic [2:0] {
    OP_CREATE  = 3'd0,
    OP_DESTROY = 3'd1,
    OP_LOOKUP  = 3'd2,
    OP_SWEEP   = 3'd3,
    OP_FIN_WK  = 3'd4,
    OP_FIN_PH  = 3'd5,
    OP_NOP6    = 3'd6,
    OP_NOP7    = 3'd7
  } wht_op_t;

  typedef enum logic [1:0] {
    ST_ACTIVE  = 2'd0,
    ST_PENDING = 2'd1,
    ST_CLEARED = 2'd2,
    ST_FREED   = 2'd3
  } wht_status_t;

  localparam logic [1:0] KIND_WEAK    = 2'd0;
  localparam logic [1:0] KIND_PHANTOM = 2'd1;
  localparam logic [1:0] KIND_SECOND  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EXEC,
    S_WALK,
    S_WALKLAST,
    S_OUT
  } wht_state_t;

endpackage

// ===== hw/rtl/weak_handle_table.sv =====
// Top level of the weak handle table: control FSM and slot memories.
// Depends on wht_pkg.
//
//  channel | direction | handshake            | payload
//  in_     | input     | in_valid / in_stall  | operation, handle id, create words, mark
//  out_    | output    | out_valid / out_stall| create, lookup, sweep, finish results
//  cfg_    | input     | cfg_we               | max_capacity
//
// Create, destroy, lookup, sweep: accept, memory read, update, result.
// A create from the free stack adds a step that reads the slot's generation.
// An invalid handle, a full table or an unknown code skips the update (accept, read, result).
// Finish weak/phantom: walk the slots below the mark, one slot per cycle through the status memory.
// One item at a time; in_stall is high from accept until the result is taken.
// Reset is synchronous; all slots read as freed since the high-water mark is 0.
// A stalled result holds in the output register; no new item enters meanwhile.
module weak_handle_table #(
  parameter int TABLE_DEPTH  = 1024,
  parameter int POINTER_BITS = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [10:0]                   cfg_max_capacity,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [2:0]                    in_operation,
  input  logic [9:0]                    in_handle_id,
  input  logic [63:0]                   in_referent,
  input  logic [1:0]                    in_handle_kind,
  input  logic [63:0]                   in_callback_word,
  input  logic [63:0]                   in_user_word,
  input  logic                          in_marked,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [9:0]                    out_new_handle,
  output logic [15:0]                   out_new_generation,
  output logic [63:0]                   out_found_referent,
  output logic                          out_alive,
  output logic                          out_callback_due,
  output logic [63:0]                   out_due_callback,
  output logic [63:0]                   out_due_user_word,
  output logic [63:0]                   out_due_referent,
  output logic [1:0]                    out_due_kind,
  output logic [10:0]                   out_settled_count
);
  import wht_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = AW + 1;
  localparam int PB = POINTER_BITS;

  // status and kind memory, payload memories, generation memory and free stack
  logic [3:0]    mem_sk  [TABLE_DEPTH];
  logic [PB-1:0] mem_ref [TABLE_DEPTH];
  logic [PB-1:0] mem_cb  [TABLE_DEPTH];
  logic [PB-1:0] mem_uw  [TABLE_DEPTH];
  logic [15:0]   mem_gen [TABLE_DEPTH];
  logic [AW-1:0] mem_fs  [TABLE_DEPTH];

  wht_state_t state_r, state_nxt;
  logic [10:0]   cap_r;
  logic [CW-1:0] free_cnt_r, mark_r;
  logic [2:0]    op_r;
  logic [9:0]    id_r;
  logic [PB-1:0] ref_in_r, cb_in_r, uw_in_r;
  logic [1:0]    kind_in_r;
  logic          marked_r;
  logic [AW-1:0] addr_r;
  logic [CW-1:0] walk_r;
  logic [10:0]   cnt_r;
  // read data
  logic [3:0]    rd_sk_r;
  logic [PB-1:0] rd_ref_r, rd_cb_r, rd_uw_r;
  logic [15:0]   rd_gen_r;
  logic [AW-1:0] rd_fs_r;

  // memory port controls
  logic [AW-1:0] rd_addr, fs_raddr, wr_addr, fs_waddr;
  logic          we_sk, we_ref, we_cb, we_uw, we_gen, we_fs;
  logic [3:0]    wd_sk;
  logic [PB-1:0] wd_ref, wd_cb, wd_uw;
  logic [15:0]   wd_gen;
  logic [AW-1:0] wd_fs_w;

  always_ff @(posedge clk) begin
    rd_sk_r  <= mem_sk[rd_addr];
    rd_ref_r <= mem_ref[rd_addr];
    rd_cb_r  <= mem_cb[rd_addr];
    rd_uw_r  <= mem_uw[rd_addr];
    rd_gen_r <= mem_gen[rd_addr];
    rd_fs_r  <= mem_fs[fs_raddr];
    if (we_sk)  mem_sk[wr_addr]  <= wd_sk;
    if (we_ref) mem_ref[wr_addr] <= wd_ref;
    if (we_cb)  mem_cb[wr_addr]  <= wd_cb;
    if (we_uw)  mem_uw[wr_addr]  <= wd_uw;
    if (we_gen) mem_gen[wr_addr] <= wd_gen;
    if (we_fs)  mem_fs[fs_waddr] <= wd_fs_w;
  end

  // effective capacity, clamped
  logic [CW:0] cap_eff;
  always_comb begin
    if (cap_r < 11'd2) cap_eff = (CW+1)'(2);
    else if (32'(cap_r) > TABLE_DEPTH) cap_eff = (CW+1)'(TABLE_DEPTH);
    else cap_eff = (CW+1)'(cap_r);
  end

  wire id_valid = (id_r != '0) && (32'(id_r) < 32'(mark_r)) && (32'(id_r) < TABLE_DEPTH);
  wire rec_live = (32'(rd_sk_r[3:2]) == 32'(ST_ACTIVE));
  // fresh slot index: mark (or 1 when the mark is still 0)
  wire [CW-1:0] fresh_idx = (mark_r == '0) ? CW'(1) : mark_r;

  logic          out_valid_r;
  logic [9:0]    o_nh_r;
  logic [15:0]   o_gen_r;
  logic [63:0]   o_fref_r, o_cb_r, o_uw_r, o_dref_r;
  logic          o_alive_r, o_due_r;
  logic [1:0]    o_dkind_r;
  logic [10:0]   o_set_r;

  logic [CW-1:0] free_cnt_nxt, mark_nxt, walk_nxt;
  logic [AW-1:0] addr_nxt;
  logic [10:0]   cnt_nxt;
  logic          load_out;
  logic [9:0]    nh;
  logic [15:0]   ngen;
  logic [63:0]   fref, dcb, duw, dref;
  logic          alv, due;
  logic [1:0]    dkind;
  logic [10:0]   sett;

  // next state, memory controls, result formation
  always_comb begin
    state_nxt = state_r;
    free_cnt_nxt = free_cnt_r;
    mark_nxt = mark_r;
    walk_nxt = walk_r;
    addr_nxt = addr_r;
    cnt_nxt = cnt_r;
    rd_addr = addr_r;
    fs_raddr = AW'(free_cnt_r - CW'(1));
    wr_addr = addr_r;
    fs_waddr = AW'(free_cnt_r);
    wd_fs_w = AW'(id_r);
    we_sk = 1'b0; we_ref = 1'b0; we_cb = 1'b0; we_uw = 1'b0; we_gen = 1'b0; we_fs = 1'b0;
    wd_sk = '0; wd_ref = ref_in_r; wd_cb = cb_in_r; wd_uw = uw_in_r; wd_gen = '0;
    load_out = 1'b0;
    nh = '0; ngen = '0; fref = '0; alv = 1'b0; due = 1'b0;
    dcb = '0; duw = '0; dref = '0; dkind = '0; sett = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_READ;
      end
      S_READ: begin
        // choose the address for this item's read
        if (wht_op_t'(op_r) == OP_CREATE) begin
          if (free_cnt_r != '0) begin
            state_nxt = S_EXEC;  // stack top arrives next cycle
          end else if ({1'b0, mark_r} >= cap_eff) begin
            load_out = 1'b1;
            state_nxt = S_OUT;
          end else begin
            // first fresh slot also claims slot zero as freed
            if (mark_r == '0) begin
              we_sk = 1'b1; wr_addr = '0; wd_sk = {ST_FREED, KIND_WEAK};
            end
            addr_nxt = AW'(fresh_idx);
            state_nxt = S_EXEC;
          end
        end else if (wht_op_t'(op_r) == OP_FIN_WK || wht_op_t'(op_r) == OP_FIN_PH) begin
          rd_addr = '0;
          addr_nxt = '0;
          walk_nxt = '0;
          cnt_nxt = '0;
          if (mark_r == '0) begin
            load_out = 1'b1;
            state_nxt = S_OUT;
          end else begin
            walk_nxt = CW'(1);
            state_nxt = S_WALK;
          end
        end else if (wht_op_t'(op_r) == OP_DESTROY || wht_op_t'(op_r) == OP_LOOKUP
                     || wht_op_t'(op_r) == OP_SWEEP) begin
          rd_addr = AW'(id_r);
          addr_nxt = AW'(id_r);
          if (id_valid) state_nxt = S_EXEC;
          else begin
            load_out = 1'b1;
            state_nxt = S_OUT;
          end
        end else begin
          load_out = 1'b1;
          state_nxt = S_OUT;
        end
      end
      S_EXEC: begin
        load_out = 1'b1;
        state_nxt = S_OUT;
        case (wht_op_t'(op_r))
          OP_CREATE: begin
            if (free_cnt_r != '0) begin
              free_cnt_nxt = free_cnt_r - CW'(1);
              wr_addr = rd_fs_r;
              // generation of a reused slot needs its old value: read it now
              rd_addr = rd_fs_r;
              addr_nxt = rd_fs_r;
              load_out = 1'b0;
              state_nxt = S_WALKLAST;
            end else begin
              mark_nxt = fresh_idx + CW'(1);
              // slot write happens in this state via addr_r, in the slot fill below
              nh = 10'(addr_r);
              ngen = '0;
            end
          end
          OP_DESTROY: begin
            if (rd_sk_r[3:2] != ST_FREED) begin
              we_sk = 1'b1; wd_sk = {ST_FREED, rd_sk_r[1:0]};
              we_ref = 1'b1; wd_ref = '0;
              we_cb = 1'b1; wd_cb = '0;
              if (32'(free_cnt_r) < TABLE_DEPTH) begin
                we_fs = 1'b1;
                free_cnt_nxt = free_cnt_r + CW'(1);
              end
            end
          end
          OP_LOOKUP: begin
            if (rec_live) begin
              fref = 64'(rd_ref_r);
              alv = (rd_ref_r != '0);
            end
          end
          OP_SWEEP: begin
            if (rec_live && rd_ref_r != '0 && !marked_r) begin
              we_ref = 1'b1; wd_ref = '0;
              we_sk = 1'b1;
              sett = 11'd1;
              if (rd_cb_r != '0) begin
                due = 1'b1;
                dcb = 64'(rd_cb_r);
                duw = 64'(rd_uw_r);
                dref = (rd_sk_r[1:0] == KIND_WEAK) ? 64'(rd_ref_r) : '0;
                dkind = rd_sk_r[1:0];
                wd_sk = {ST_PENDING, rd_sk_r[1:0]};
              end else begin
                wd_sk = {ST_CLEARED, rd_sk_r[1:0]};
              end
            end
          end
          default: ;
        endcase
      end
      S_WALK: begin
        // data for slot addr_r arrives; read the next one
        rd_addr = AW'(walk_r);
        addr_nxt = AW'(walk_r);
        if (rd_sk_r[3:2] == ST_PENDING &&
            ((rd_sk_r[1:0] == KIND_PHANTOM) == (wht_op_t'(op_r) == OP_FIN_PH))) begin
          we_sk = 1'b1; wd_sk = {ST_CLEARED, rd_sk_r[1:0]};
          cnt_nxt = cnt_r + 11'd1;
        end
        if (walk_r == mark_r || 32'(walk_r) >= TABLE_DEPTH) begin
          load_out = 1'b1;
          sett = (we_sk) ? cnt_r + 11'd1 : cnt_r;
          state_nxt = S_OUT;
        end else begin
          walk_nxt = walk_r + CW'(1);
        end
      end
      S_WALKLAST: begin
        // reused slot: bump its generation
        load_out = 1'b1;
        state_nxt = S_OUT;
        we_gen = 1'b1; wd_gen = rd_gen_r + 16'd1;
        nh = 10'(addr_r);
        ngen = rd_gen_r + 16'd1;
      end
      S_OUT: begin
        if (!out_stall) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    // slot fill for create, once the slot is fixed
    if (load_out && wht_op_t'(op_r) == OP_CREATE && nh != '0) begin
      we_sk = 1'b1; wr_addr = addr_r;
      wd_sk = {ST_ACTIVE, (kind_in_r == 2'd3) ? KIND_SECOND : kind_in_r};
      we_ref = 1'b1; wd_ref = ref_in_r;
      we_cb = 1'b1; wd_cb = cb_in_r;
      we_uw = 1'b1; wd_uw = uw_in_r;
      if (state_r == S_EXEC) begin
        we_gen = 1'b1; wd_gen = '0;
      end
    end
  end

  assign in_stall = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cap_r <= 11'd1024;
      free_cnt_r <= '0;
      mark_r <= '0;
      out_valid_r <= 1'b0;
      walk_r <= '0;
      cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) cap_r <= cfg_max_capacity;
      free_cnt_r <= free_cnt_nxt;
      mark_r <= mark_nxt;
      walk_r <= walk_nxt;
      cnt_r <= cnt_nxt;
      if (load_out) out_valid_r <= 1'b1;
      else if (state_r == S_OUT && !out_stall) out_valid_r <= 1'b0;
    end
  end

  // item capture and result registers
  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    if (state_r == S_IDLE && in_valid) begin
      op_r <= in_operation;
      id_r <= in_handle_id;
      ref_in_r <= PB'(in_referent);
      cb_in_r <= PB'(in_callback_word);
      uw_in_r <= PB'(in_user_word);
      kind_in_r <= in_handle_kind;
      marked_r <= in_marked;
    end
    if (load_out) begin
      o_nh_r <= nh; o_gen_r <= ngen; o_fref_r <= fref; o_alive_r <= alv;
      o_due_r <= due; o_cb_r <= dcb; o_uw_r <= duw; o_dref_r <= dref;
      o_dkind_r <= dkind; o_set_r <= sett;
    end
  end

  assign out_valid = out_valid_r;
  assign out_new_handle = o_nh_r;
  assign out_new_generation = o_gen_r;
  assign out_found_referent = o_fref_r;
  assign out_alive = o_alive_r;
  assign out_callback_due = o_due_r;
  assign out_due_callback = o_cb_r;
  assign out_due_user_word = o_uw_r;
  assign out_due_referent = o_dref_r;
  assign out_due_kind = o_dkind_r;
  assign out_settled_count = o_set_r;

endmodule

// ===== hw/rtl/wht_checker.sv =====
// Port-level checker for the weak handle table, bound to the top level.
// Depends on wht_pkg.
module wht_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_alive,
  input logic [63:0] out_found_referent,
  input logic        out_callback_due,
  input logic [10:0] out_settled_count,
  input logic [9:0]  out_new_handle,
  input logic [15:0] out_new_generation
);
  import wht_pkg::*;

  // a result that is alive names a nonzero referent
  a_alive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_alive |-> out_found_referent != '0) else $error("alive with zero referent");

  // a queued callback always counts as settled
  a_due: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_callback_due |-> out_settled_count == 11'd1) else $error("due without settle");

  // failed create carries no generation
  a_gen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_new_handle == '0 |-> out_new_generation == '0) else $error("gen on empty");

  // one item at a time: while a result is shown, no input is taken
  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input taken with result pending");

  // a stalled result stays
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid) else $error("result dropped");

endmodule

bind weak_handle_table wht_checker u_wht_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_alive(out_alive),
  .out_found_referent(out_found_referent), .out_callback_due(out_callback_due),
  .out_settled_count(out_settled_count), .out_new_handle(out_new_handle),
  .out_new_generation(out_new_generation)
);
